@@ design/tslft_pkg.sv @@
// shared types and constants for the typed stack label and frame tracker
// no dependencies

package tslft_pkg;

   localparam int STACK_DEPTH  = 1024;
   localparam int PAYLOAD_BITS = 64;
   localparam int IDX_W        = $clog2(STACK_DEPTH);
   localparam int CNT_W        = IDX_W + 1;

   typedef enum logic [1:0] {
      MODE_VALUE = 2'd0,
      MODE_LABEL = 2'd1,
      MODE_FRAME = 2'd2,
      MODE_POP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_LABEL = 2'd1,
      KIND_FRAME = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // context of one stack entry as seen scanning downward from it
   typedef struct packed {
      logic             lbl_ok;
      logic [IDX_W-1:0] lbl_idx;
      logic [CNT_W-1:0] cnt;
      logic             frm_ok;
      logic [IDX_W-1:0] frm_idx;
   } link_type;

   // link holds the context of the entry directly below
   typedef struct packed {
      link_type                link;
      kind_type                kind;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      mode_type                mode;
      logic [PAYLOAD_BITS-1:0] payload;
   } cmd_type;

   // first field in the highest bits
   typedef struct packed {
      logic [1:0]       pad;
      err_type          error_code;
      logic             frame_present;
      logic [IDX_W-1:0] frame_position;
      logic             label_present;
      logic [IDX_W-1:0] label_position;
      logic [CNT_W-1:0] values_above_label;
      logic [CNT_W-1:0] stack_depth;
      logic [63:0]      popped_payload;
   } rsp_data_type;

   localparam int RSP_TDATA_W = $bits(rsp_data_type);

   typedef struct packed {
      kind_type     popped_kind;
      rsp_data_type data;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic commit;
   } step_type;

   function automatic kind_type mode_to_kind(input mode_type mode);
      kind_type kind;
      unique case (mode)
         MODE_VALUE: kind = KIND_VALUE;
         MODE_LABEL: kind = KIND_LABEL;
         MODE_FRAME: kind = KIND_FRAME;
         default:    kind = KIND_NONE;
      endcase
      return kind;
   endfunction

endpackage

@@ design/tslft_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module tslft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tslft_track.sv @@
// stack state registers and the read-modify-write of the entry memory
// depends on tslft_pkg and tslft_ram

module tslft_track (
   input  logic                clock,
   input  logic                reset,
   input  tslft_pkg::step_type step,
   input  tslft_pkg::cmd_type  cmd,
   output tslft_pkg::rsp_type  result
);

   logic [tslft_pkg::CNT_W-1:0] top_ff, top_in;
   logic [tslft_pkg::CNT_W-1:0] vcnt_ff, vcnt_in;
   logic                        lbl_ok_ff, lbl_ok_in;
   logic [tslft_pkg::IDX_W-1:0] lbl_idx_ff, lbl_idx_in;
   logic                        frm_ok_ff, frm_ok_in;
   logic [tslft_pkg::IDX_W-1:0] frm_idx_ff, frm_idx_in;
   tslft_pkg::link_type         link_ff, link_in;

   logic [tslft_pkg::CNT_W-1:0] top_dec;
   logic                        wr_ok;
   tslft_pkg::entry_type        wr_entry;
   tslft_pkg::entry_type        rd_entry;
   logic [tslft_pkg::ENTRY_W-1:0] rd_bits;
   tslft_pkg::err_type          err;
   tslft_pkg::kind_type         pkind;
   logic [63:0]                 ppay;

   assign top_dec = top_ff - tslft_pkg::CNT_W'(1);

   tslft_ram #(
      .WIDTH(tslft_pkg::ENTRY_W),
      .DEPTH(tslft_pkg::STACK_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (step.commit && wr_ok),
      .wr_addr(top_ff[tslft_pkg::IDX_W-1:0]),
      .wr_data(wr_entry),
      .rd_en  (step.start),
      .rd_addr(top_dec[tslft_pkg::IDX_W-1:0]),
      .rd_data(rd_bits)
   );

   assign rd_entry         = tslft_pkg::entry_type'(rd_bits);
   assign wr_entry.link    = link_ff;
   assign wr_entry.kind    = tslft_pkg::mode_to_kind(cmd.mode);
   assign wr_entry.payload = cmd.payload;

   always_comb begin
      top_in     = top_ff;
      vcnt_in    = vcnt_ff;
      lbl_ok_in  = lbl_ok_ff;
      lbl_idx_in = lbl_idx_ff;
      frm_ok_in  = frm_ok_ff;
      frm_idx_in = frm_idx_ff;
      link_in    = link_ff;
      wr_ok      = 1'b0;
      err        = tslft_pkg::ERR_OK;
      pkind      = tslft_pkg::KIND_NONE;
      ppay       = '0;
      if (cmd.mode != tslft_pkg::MODE_POP) begin
         if (top_ff == tslft_pkg::CNT_W'(tslft_pkg::STACK_DEPTH)) begin
            err = tslft_pkg::ERR_FULL;
         end else begin
            wr_ok  = 1'b1;
            top_in = top_ff + tslft_pkg::CNT_W'(1);
            unique case (cmd.mode)
               tslft_pkg::MODE_VALUE: begin
                  vcnt_in     = vcnt_ff + tslft_pkg::CNT_W'(1);
                  link_in.cnt = link_ff.cnt + tslft_pkg::CNT_W'(1);
               end
               tslft_pkg::MODE_LABEL: begin
                  vcnt_in         = '0;
                  lbl_ok_in       = 1'b1;
                  lbl_idx_in      = top_ff[tslft_pkg::IDX_W-1:0];
                  link_in.lbl_ok  = 1'b1;
                  link_in.lbl_idx = top_ff[tslft_pkg::IDX_W-1:0];
                  link_in.cnt     = '0;
               end
               default: begin
                  frm_ok_in       = 1'b1;
                  frm_idx_in      = top_ff[tslft_pkg::IDX_W-1:0];
                  link_in.lbl_ok  = 1'b0;
                  link_in.lbl_idx = '0;
                  link_in.cnt     = '0;
                  link_in.frm_ok  = 1'b1;
                  link_in.frm_idx = top_ff[tslft_pkg::IDX_W-1:0];
               end
            endcase
         end
      end else if (top_ff == '0) begin
         err = tslft_pkg::ERR_EMPTY;
      end else begin
         top_in  = top_dec;
         pkind   = rd_entry.kind;
         ppay    = 64'(rd_entry.payload);
         link_in = rd_entry.link;
         unique case (rd_entry.kind)
            tslft_pkg::KIND_LABEL: begin
               lbl_ok_in  = rd_entry.link.lbl_ok;
               lbl_idx_in = rd_entry.link.lbl_idx;
               vcnt_in    = rd_entry.link.cnt;
            end
            tslft_pkg::KIND_FRAME: begin
               frm_ok_in  = rd_entry.link.frm_ok;
               frm_idx_in = rd_entry.link.frm_idx;
               if (!lbl_ok_ff) begin
                  lbl_ok_in  = rd_entry.link.lbl_ok;
                  lbl_idx_in = rd_entry.link.lbl_idx;
               end
            end
            default: begin
               if (vcnt_ff != '0) begin
                  vcnt_in = vcnt_ff - tslft_pkg::CNT_W'(1);
               end
            end
         endcase
      end
   end

   always_comb begin
      result.popped_kind             = pkind;
      result.data.pad                = '0;
      result.data.error_code         = err;
      result.data.frame_present      = frm_ok_in;
      result.data.frame_position     = frm_idx_in;
      result.data.label_present      = lbl_ok_in;
      result.data.label_position     = lbl_idx_in;
      result.data.values_above_label = vcnt_in;
      result.data.stack_depth        = top_in;
      result.data.popped_payload     = ppay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= '0;
         vcnt_ff    <= '0;
         lbl_ok_ff  <= 1'b0;
         lbl_idx_ff <= '0;
         frm_ok_ff  <= 1'b0;
         frm_idx_ff <= '0;
         link_ff    <= '0;
      end else if (step.commit) begin
         top_ff     <= top_in;
         vcnt_ff    <= vcnt_in;
         lbl_ok_ff  <= lbl_ok_in;
         lbl_idx_ff <= lbl_idx_in;
         frm_ok_ff  <= frm_ok_in;
         frm_idx_ff <= frm_idx_in;
         link_ff    <= link_in;
      end
   end

endmodule

@@ design/tslft_ctrl.sv @@
// request sequencing, command capture and output register
// depends on tslft_pkg

module tslft_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tslft_pkg::cmd_type  req_cmd,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output tslft_pkg::rsp_type  rsp_out,
   output tslft_pkg::step_type step,
   output tslft_pkg::cmd_type  cmd,
   input  tslft_pkg::rsp_type  result
);

   tslft_pkg::state_type state_ff, state_in;
   tslft_pkg::cmd_type   cmd_ff;
   tslft_pkg::rsp_type   out_ff;
   logic                 out_valid_ff, out_valid_in;
   logic                 accept;
   logic                 commit;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tslft_pkg::ST_IDLE: if (accept) state_in = tslft_pkg::ST_EXEC;
         tslft_pkg::ST_EXEC: if (commit) state_in = tslft_pkg::ST_IDLE;
         default:            state_in = tslft_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      unique case (state_ff)
         tslft_pkg::ST_IDLE: req_tready = 1'b1;
         tslft_pkg::ST_EXEC: commit = !out_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            commit     = 1'b0;
         end
      endcase
   end

   assign step.start  = accept;
   assign step.commit = commit;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tslft_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
      end
      if (commit) begin
         out_ff <= result;
      end
   end

   assign cmd        = cmd_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_out    = out_ff;

endmodule

@@ design/typed_stack_label_frame_tracker.sv @@
// Typed value/label/frame stack with current label and frame tracking. Each request has
// an accept cycle and an execute state: the accept cycle reads the top entry of the entry
// memory (1024 deep, one registered read port), the execute state computes the new state,
// writes a pushed entry and loads the output register. Label and frame pops cost the same
// as any other request since every entry stores the scan context of the entry below it, so
// no stack walk is needed. A new request is taken only once the last one has left the
// execute state; a result left waiting in the output register holds the next request in
// its execute state. There is no clearing pass after reset.
// top level, depends on tslft_pkg, tslft_ctrl, tslft_track and tslft_ram

module typed_stack_label_frame_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,  // payload
   input  logic [1:0]                        req_tuser,  // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // popped_payload, stack_depth, values_above_label, label_position, label_present,
   // frame_position, frame_present, error_code, zero fill
   output logic [tslft_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]                        rsp_tuser   // popped_kind
);

   tslft_pkg::cmd_type  req_cmd;
   tslft_pkg::cmd_type  cmd;
   tslft_pkg::step_type step;
   tslft_pkg::rsp_type  result;
   tslft_pkg::rsp_type  rsp_out;

   assign req_cmd.mode    = tslft_pkg::mode_type'(req_tuser);
   assign req_cmd.payload = req_tdata[tslft_pkg::PAYLOAD_BITS-1:0];

   tslft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_cmd   (req_cmd),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_out   (rsp_out),
      .step      (step),
      .cmd       (cmd),
      .result    (result)
   );

   tslft_track u_track (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cmd   (cmd),
      .result(result)
   );

   assign rsp_tdata = rsp_out.data;
   assign rsp_tuser = rsp_out.popped_kind;

endmodule

@@ design/tslft_check.sv @@
// port-level checks for the typed stack label and frame tracker
// depends on tslft_pkg, bound to typed_stack_label_frame_tracker

module tslft_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [63:0]                       req_tdata,
   input logic [1:0]                        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tslft_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]                        rsp_tuser
);

   tslft_pkg::rsp_data_type data;

   assign data = tslft_pkg::rsp_data_type'(rsp_tdata);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one request in flight at a time
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // an empty pop leaves nothing popped and an empty stack
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && data.error_code == tslft_pkg::ERR_EMPTY |->
         rsp_tuser == tslft_pkg::KIND_NONE && data.stack_depth == '0 &&
         data.popped_payload == '0)
      else $error("bad empty pop result");

   // absent label or frame reports position zero
   a_absent_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (data.label_present || data.label_position == '0) &&
         (data.frame_present || data.frame_position == '0))
      else $error("absent label or frame with nonzero position");

endmodule

bind typed_stack_label_frame_tracker tslft_check u_tslft_check (.*);
